### rtl/ghp_pkg.sv
// package for the gzip member header parser: phase and status codes, flag masks
// and helper functions for the phase sequence after the fixed header part
// no dependencies
`default_nettype none

package ghp_pkg;

	// header phase
	typedef enum logic [3:0] {
		PH_MAGIC0  = 4'd0,
		PH_MAGIC1  = 4'd1,
		PH_METHOD  = 4'd2,
		PH_FLAGS   = 4'd3,
		PH_FIXED   = 4'd4,
		PH_XLEN_LO = 4'd5,
		PH_XLEN_HI = 4'd6,
		PH_XSKIP   = 4'd7,
		PH_NAME    = 4'd8,
		PH_COMMENT = 4'd9,
		PH_STOPPED = 4'd10
	} phase_t;

	// status reported with every item
	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_DONE    = 3'd1,
		ST_MAGIC   = 3'd2,
		ST_CRYPT   = 3'd3,
		ST_MULTI   = 3'd4,
		ST_RESV    = 3'd5,
		ST_STOPPED = 3'd6
	} status_t;

	// magic bytes
	localparam logic [7:0] MAGIC_ID1     = 8'h1F;
	localparam logic [7:0] MAGIC_ID2     = 8'h8B;
	localparam logic [7:0] MAGIC_ID2_OLD = 8'h9E;

	// flag masks
	localparam logic [7:0] FL_MULTI    = 8'h02;
	localparam logic [7:0] FL_EXTRA    = 8'h04;
	localparam logic [7:0] FL_NAME     = 8'h08;
	localparam logic [7:0] FL_COMMENT  = 8'h10;
	localparam logic [7:0] FL_CRYPT    = 8'h20;
	localparam logic [7:0] FL_RESERVED = 8'hC0;

	// timestamp, extra flags and os bytes
	localparam logic [15:0] FIXED_LEN = 16'd6;

	// phase after the name field
	function automatic phase_t after_name(input logic [7:0] flags);
		after_name = ((flags & FL_COMMENT) != 8'h00) ? PH_COMMENT : PH_MAGIC0;
	endfunction

	// phase after the extra field
	function automatic phase_t after_extra(input logic [7:0] flags);
		after_extra = ((flags & FL_NAME) != 8'h00) ? PH_NAME : after_name(flags);
	endfunction

	// phase after the fixed part
	function automatic phase_t after_fixed(input logic [7:0] flags);
		after_fixed = ((flags & FL_EXTRA) != 8'h00) ? PH_XLEN_LO : after_extra(flags);
	endfunction

endpackage

`default_nettype wire

### rtl/ghp_if.sv
// valid/ready channels of the gzip header parser: header bytes in, status out
// depends on nothing
`default_nettype none

interface ghp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface ghp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] method_code;
	logic [7:0] flag_bits;

	modport source (output valid, output status, output method_code, output flag_bits,
		input ready);
	modport sink   (input valid, input status, input method_code, input flag_bits,
		output ready);
endinterface

`default_nettype wire

### rtl/gzip_header_parser_top.sv
// gzip member header parser, one header byte per item, one status item per byte
// depends on ghp_pkg and the channel interfaces in ghp_if.sv
//
//   channel   direction  payload                               handshake
//   bytes     in         data_byte[7:0]                        valid/ready
//   results   out        status[2:0] method_code[7:0]          valid/ready
//                        flag_bits[7:0]
//
// an item passes an input register and a result register; one item per cycle is sustained
// while results are taken, set by the single phase update per byte
// the input register refills while the result register waits, so a stall on
// results backs up through ready one stage at a time
// arst_n clears the phase to waiting for magic and empties both registers
// after an error the phase stays stopped until reset
`default_nettype none

module gzip_header_parser_top (
	input  wire              clk,
	input  wire              arst_n,
	ghp_byte_if.sink         bytes,
	ghp_result_if.source     results
);

	// pipeline registers
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        valid_s2;
	logic [2:0]  status_s2;
	logic [7:0]  method_s2;
	logic [7:0]  flags_s2;

	// header state
	ghp_pkg::phase_t phase_q;
	logic [7:0]      first_magic_q;
	logic [7:0]      method_q;
	logic [7:0]      flags_q;
	logic [15:0]     skip_q;

	// combinational results
	ghp_pkg::phase_t  phase_d;
	ghp_pkg::status_t status_d;
	logic [7:0]       first_magic_d;
	logic [7:0]       method_d;
	logic [7:0]       flags_d;
	logic [15:0]      skip_d;
	logic [15:0]      skip_dec;
	logic [15:0]      xlen;
	logic             advance;

	// handshake
	assign advance      = valid_s1 && (!valid_s2 || results.ready);
	assign bytes.ready  = !valid_s1 || advance;

	assign skip_dec = skip_q - 16'd1;
	assign xlen     = {data_s1, skip_q[7:0]};

	// next phase
	always_comb begin
		unique case (phase_q)
			ghp_pkg::PH_MAGIC0: begin
				phase_d = ghp_pkg::PH_MAGIC1;
			end
			ghp_pkg::PH_MAGIC1: begin
				if (first_magic_q == ghp_pkg::MAGIC_ID1 &&
				    (data_s1 == ghp_pkg::MAGIC_ID2 || data_s1 == ghp_pkg::MAGIC_ID2_OLD)) begin
					phase_d = ghp_pkg::PH_METHOD;
				end else begin
					phase_d = ghp_pkg::PH_STOPPED;
				end
			end
			ghp_pkg::PH_METHOD: begin
				phase_d = ghp_pkg::PH_FLAGS;
			end
			ghp_pkg::PH_FLAGS: begin
				if ((data_s1 & (ghp_pkg::FL_CRYPT | ghp_pkg::FL_MULTI |
				                ghp_pkg::FL_RESERVED)) != 8'h00) begin
					phase_d = ghp_pkg::PH_STOPPED;
				end else begin
					phase_d = ghp_pkg::PH_FIXED;
				end
			end
			ghp_pkg::PH_FIXED: begin
				phase_d = (skip_dec == 16'd0) ? ghp_pkg::after_fixed(flags_q)
				                              : ghp_pkg::PH_FIXED;
			end
			ghp_pkg::PH_XLEN_LO: begin
				phase_d = ghp_pkg::PH_XLEN_HI;
			end
			ghp_pkg::PH_XLEN_HI: begin
				phase_d = (xlen == 16'd0) ? ghp_pkg::after_extra(flags_q)
				                          : ghp_pkg::PH_XSKIP;
			end
			ghp_pkg::PH_XSKIP: begin
				phase_d = (skip_dec == 16'd0) ? ghp_pkg::after_extra(flags_q)
				                              : ghp_pkg::PH_XSKIP;
			end
			ghp_pkg::PH_NAME: begin
				phase_d = (data_s1 == 8'h00) ? ghp_pkg::after_name(flags_q)
				                             : ghp_pkg::PH_NAME;
			end
			ghp_pkg::PH_COMMENT: begin
				phase_d = (data_s1 == 8'h00) ? ghp_pkg::PH_MAGIC0 : ghp_pkg::PH_COMMENT;
			end
			default: begin
				phase_d = ghp_pkg::PH_STOPPED;
			end
		endcase
	end

	// status and header field updates
	always_comb begin
		status_d      = ghp_pkg::ST_BUSY;
		first_magic_d = first_magic_q;
		method_d      = method_q;
		flags_d       = flags_q;
		skip_d        = skip_q;
		unique case (phase_q)
			ghp_pkg::PH_MAGIC0: begin
				first_magic_d = data_s1;
			end
			ghp_pkg::PH_MAGIC1: begin
				if (phase_d == ghp_pkg::PH_STOPPED) begin
					status_d = ghp_pkg::ST_MAGIC;
				end
			end
			ghp_pkg::PH_METHOD: begin
				method_d = data_s1;
			end
			ghp_pkg::PH_FLAGS: begin
				flags_d = data_s1;
				// encrypted wins over multipart, multipart over reserved
				priority if ((data_s1 & ghp_pkg::FL_CRYPT) != 8'h00) begin
					status_d = ghp_pkg::ST_CRYPT;
				end else if ((data_s1 & ghp_pkg::FL_MULTI) != 8'h00) begin
					status_d = ghp_pkg::ST_MULTI;
				end else if ((data_s1 & ghp_pkg::FL_RESERVED) != 8'h00) begin
					status_d = ghp_pkg::ST_RESV;
				end else begin
					skip_d = ghp_pkg::FIXED_LEN;
				end
			end
			ghp_pkg::PH_FIXED, ghp_pkg::PH_XSKIP: begin
				skip_d = skip_dec;
				if (phase_d == ghp_pkg::PH_MAGIC0) begin
					status_d = ghp_pkg::ST_DONE;
				end
			end
			ghp_pkg::PH_XLEN_LO: begin
				skip_d = {8'h00, data_s1};
			end
			ghp_pkg::PH_XLEN_HI: begin
				skip_d = xlen;
				if (phase_d == ghp_pkg::PH_MAGIC0) begin
					status_d = ghp_pkg::ST_DONE;
				end
			end
			ghp_pkg::PH_NAME, ghp_pkg::PH_COMMENT: begin
				if (phase_d == ghp_pkg::PH_MAGIC0) begin
					status_d = ghp_pkg::ST_DONE;
				end
			end
			default: begin
				status_d = ghp_pkg::ST_STOPPED;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			data_s1 <= bytes.data_byte;
		end
	end

	// header state, updated as an item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ghp_pkg::PH_MAGIC0;
			first_magic_q <= 8'h00;
			method_q      <= 8'h00;
			flags_q       <= 8'h00;
			skip_q        <= 16'd0;
		end else if (advance) begin
			phase_q       <= phase_d;
			first_magic_q <= first_magic_d;
			method_q      <= method_d;
			flags_q       <= flags_d;
			skip_q        <= skip_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_d;
			method_s2 <= (status_d == ghp_pkg::ST_DONE) ? method_q : 8'h00;
			flags_s2  <= (status_d == ghp_pkg::ST_DONE) ? flags_q : 8'h00;
		end
	end

	assign results.valid       = valid_s2;
	assign results.status      = status_s2;
	assign results.method_code = method_s2;
	assign results.flag_bits   = flags_s2;

endmodule

`default_nettype wire

### rtl/ghp_checker.sv
// port-level checks for gzip_header_parser_top, bound to the top level
// depends on ghp_pkg
`default_nettype none

module ghp_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       res_valid,
	input wire       res_ready,
	input wire [2:0] status,
	input wire [7:0] method_code,
	input wire [7:0] flag_bits
);

	logic err_seen_q;
	logic is_err;

	assign is_err = (status == ghp_pkg::ST_MAGIC) || (status == ghp_pkg::ST_CRYPT) ||
	                (status == ghp_pkg::ST_MULTI) || (status == ghp_pkg::ST_RESV);

	// remember that an error item was delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (res_valid && res_ready && is_err) begin
			err_seen_q <= 1'b1;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) &&
		$stable(method_code) && $stable(flag_bits))
		else $error("result changed while stalled");

	// method and flags only shown on completion
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ghp_pkg::ST_DONE |-> method_code == 8'h00 && flag_bits == 8'h00)
		else $error("method or flags nonzero without completion");

	// a completed header never carries rejected flags
	a_done_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ghp_pkg::ST_DONE |->
		(flag_bits & (ghp_pkg::FL_CRYPT | ghp_pkg::FL_MULTI | ghp_pkg::FL_RESERVED)) == 8'h00)
		else $error("completion with rejected flag bits");

	// after an error every item reports stopped
	a_stay_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && err_seen_q |-> status == ghp_pkg::ST_STOPPED)
		else $error("parser left the stopped state after an error");

endmodule

bind gzip_header_parser_top ghp_checker u_ghp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.status      (results.status),
	.method_code (results.method_code),
	.flag_bits   (results.flag_bits)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench for gzip_header_parser_top: feeds gzip member headers one byte per item and
// checks every status item against a header predictor held in a small scoreboard class
// depends on ghp_pkg and the byte and result channels in ghp_if.sv

// one expected status item
typedef struct {
	ghp_pkg::status_t status;
	logic [7:0]       method_code;
	logic [7:0]       flag_bits;
} hdr_status_t;

// ways the closing header is broken
typedef enum {
	BRK_ID1,
	BRK_ID2,
	BRK_CRYPT,
	BRK_MULTI,
	BRK_RESV
} break_kind_t;

class hdr_scoreboard;
	ghp_pkg::phase_t phase;
	logic [7:0]      magic_lo;
	logic [7:0]      method;
	logic [7:0]      flags;
	logic [15:0]     remaining;
	hdr_status_t     expected_q[$];
	int unsigned     mismatches;
	int unsigned     headers_done;

	function new();
		phase = ghp_pkg::PH_MAGIC0;
		magic_lo = 8'h00;
		method = 8'h00;
		flags = 8'h00;
		remaining = 16'h0000;
		mismatches = 0;
		headers_done = 0;
	endfunction

	// next optional field once the given one is finished
	function ghp_pkg::phase_t field_after(ghp_pkg::phase_t finished);
		if (finished == ghp_pkg::PH_FIXED && (flags & ghp_pkg::FL_EXTRA) != 8'h00)
			return ghp_pkg::PH_XLEN_LO;
		if (finished != ghp_pkg::PH_NAME && (flags & ghp_pkg::FL_NAME) != 8'h00)
			return ghp_pkg::PH_NAME;
		if ((flags & ghp_pkg::FL_COMMENT) != 8'h00)
			return ghp_pkg::PH_COMMENT;
		return ghp_pkg::PH_MAGIC0;
	endfunction

	// advance the header phase by one accepted byte and queue its status
	function void note_byte(logic [7:0] b);
		ghp_pkg::status_t st;
		ghp_pkg::phase_t  nxt;
		hdr_status_t      item;
		st = ghp_pkg::ST_BUSY;
		nxt = phase;
		case (phase)
			ghp_pkg::PH_MAGIC0: begin
				magic_lo = b;
				nxt = ghp_pkg::PH_MAGIC1;
			end
			ghp_pkg::PH_MAGIC1: begin
				if (magic_lo == ghp_pkg::MAGIC_ID1 &&
				    (b == ghp_pkg::MAGIC_ID2 || b == ghp_pkg::MAGIC_ID2_OLD)) begin
					nxt = ghp_pkg::PH_METHOD;
				end else begin
					st = ghp_pkg::ST_MAGIC;
					nxt = ghp_pkg::PH_STOPPED;
				end
			end
			ghp_pkg::PH_METHOD: begin
				method = b;
				nxt = ghp_pkg::PH_FLAGS;
			end
			ghp_pkg::PH_FLAGS: begin
				flags = b;
				nxt = ghp_pkg::PH_STOPPED;
				// encrypted wins over multipart, multipart over reserved
				if ((b & ghp_pkg::FL_CRYPT) != 8'h00)
					st = ghp_pkg::ST_CRYPT;
				else if ((b & ghp_pkg::FL_MULTI) != 8'h00)
					st = ghp_pkg::ST_MULTI;
				else if ((b & ghp_pkg::FL_RESERVED) != 8'h00)
					st = ghp_pkg::ST_RESV;
				else begin
					remaining = ghp_pkg::FIXED_LEN;
					nxt = ghp_pkg::PH_FIXED;
				end
			end
			ghp_pkg::PH_FIXED: begin
				remaining = remaining - 16'd1;
				nxt = (remaining == 16'd0) ? field_after(ghp_pkg::PH_FIXED)
				                           : ghp_pkg::PH_FIXED;
			end
			ghp_pkg::PH_XLEN_LO: begin
				remaining = {8'h00, b};
				nxt = ghp_pkg::PH_XLEN_HI;
			end
			ghp_pkg::PH_XLEN_HI: begin
				// a zero length ends the extra field here
				remaining = {b, remaining[7:0]};
				nxt = (remaining == 16'd0) ? field_after(ghp_pkg::PH_XSKIP)
				                           : ghp_pkg::PH_XSKIP;
			end
			ghp_pkg::PH_XSKIP: begin
				remaining = remaining - 16'd1;
				nxt = (remaining == 16'd0) ? field_after(ghp_pkg::PH_XSKIP)
				                           : ghp_pkg::PH_XSKIP;
			end
			ghp_pkg::PH_NAME: begin
				nxt = (b == 8'h00) ? field_after(ghp_pkg::PH_NAME) : ghp_pkg::PH_NAME;
			end
			ghp_pkg::PH_COMMENT: begin
				nxt = (b == 8'h00) ? ghp_pkg::PH_MAGIC0 : ghp_pkg::PH_COMMENT;
			end
			default: begin
				st = ghp_pkg::ST_STOPPED;
				nxt = ghp_pkg::PH_STOPPED;
			end
		endcase
		// last byte of a header
		if (phase >= ghp_pkg::PH_FIXED && phase <= ghp_pkg::PH_COMMENT &&
		    nxt == ghp_pkg::PH_MAGIC0)
			st = ghp_pkg::ST_DONE;
		phase = nxt;
		item.status = st;
		item.method_code = (st == ghp_pkg::ST_DONE) ? method : 8'h00;
		item.flag_bits = (st == ghp_pkg::ST_DONE) ? flags : 8'h00;
		expected_q.push_back(item);
	endfunction

	// compare one status item with the oldest expectation
	function void check_result(logic [2:0] status, logic [7:0] method_code,
		logic [7:0] flag_bits);
		hdr_status_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: status item with nothing expected: status %0d method %02h flags %02h",
				$time, status, method_code, flag_bits);
			mismatches++;
			return;
		end
		want = expected_q.pop_front();
		if (status !== want.status) begin
			$display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, status);
			mismatches++;
		end
		if (method_code !== want.method_code) begin
			$display("%0t: method_code mismatch: expected %02h actual %02h", $time,
				want.method_code, method_code);
			mismatches++;
		end
		if (flag_bits !== want.flag_bits) begin
			$display("%0t: flag_bits mismatch: expected %02h actual %02h", $time,
				want.flag_bits, flag_bits);
			mismatches++;
		end
		if (want.status == ghp_pkg::ST_DONE)
			headers_done++;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_top;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned MAX_GAP      = 12;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned TARGET_BYTES = 1130;

	logic clk;
	logic arst_n;

	ghp_byte_if   byte_ch();
	ghp_result_if res_ch();

	gzip_header_parser_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (res_ch)
	);

	hdr_scoreboard sb = new();
	int unsigned   bytes_sent = 0;
	int unsigned   cycle_count = 0;
	bit            hold_request = 1'b0;
	bit            sender_burst = 1'b0;
	break_kind_t   closing_kind = BRK_ID1;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// check every accepted status item
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.status, res_ch.method_code, res_ch.flag_bits);
	end

	// result side: random stalls, quiet stretches and one long hold-off
	initial begin : result_sink
		int          stall;
		int unsigned taken;
		taken = 0;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (HOLD_CYCLES) begin
					res_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			stall = (taken % 50 < 12) ? 0 : $urandom_range(0, MAX_GAP);
			repeat (stall) begin
				res_ch.ready <= 1'b0;
				@(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken++;
		end
	end

	// offer one byte after a random gap and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (sender_burst || bytes_sent % 64 < 16) ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// stop offering until every expected status item has come back
	task automatic wait_results_drained();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// one well-formed header with random fixed bytes and random field content
	task automatic send_header(input logic [7:0] id2, input logic [7:0] method,
		input logic [7:0] flags, input logic [15:0] xlen, input int name_len,
		input int cmt_len);
		send_byte(ghp_pkg::MAGIC_ID1);
		send_byte(id2);
		send_byte(method);
		send_byte(flags);
		repeat (ghp_pkg::FIXED_LEN) send_byte(8'($urandom_range(0, 255)));
		if ((flags & ghp_pkg::FL_EXTRA) != 8'h00) begin
			send_byte(xlen[7:0]);
			send_byte(xlen[15:8]);
			repeat (xlen) send_byte(8'($urandom_range(0, 255)));
		end
		if ((flags & ghp_pkg::FL_NAME) != 8'h00) begin
			repeat (name_len) send_byte(8'($urandom_range(1, 255)));
			send_byte(8'h00);
		end
		if ((flags & ghp_pkg::FL_COMMENT) != 8'h00) begin
			repeat (cmt_len) send_byte(8'($urandom_range(1, 255)));
			send_byte(8'h00);
		end
	endtask

	// random legal flags, mostly short extra fields, now and then a long one
	task automatic send_random_header();
		logic [7:0]  flags;
		logic [15:0] xlen;
		logic [7:0]  id2;
		flags = 8'($urandom_range(0, 255)) &
			(ghp_pkg::FL_EXTRA | ghp_pkg::FL_NAME | ghp_pkg::FL_COMMENT | 8'h01);
		if ($urandom_range(0, 24) == 0)
			xlen = 16'($urandom_range(256, 300));
		else
			xlen = 16'($urandom_range(0, 8));
		id2 = ($urandom_range(0, 1) == 0) ? ghp_pkg::MAGIC_ID2 : ghp_pkg::MAGIC_ID2_OLD;
		send_header(id2, 8'($urandom_range(0, 255)), flags, xlen,
			$urandom_range(0, 10), $urandom_range(0, 10));
	endtask

	// a header that stops the parser for good, then bytes that must all read stopped
	task automatic send_broken_header();
		logic [7:0] b;
		logic [7:0] flags;
		closing_kind = break_kind_t'($urandom_range(0, 4));
		flags = 8'($urandom_range(0, 255));
		case (closing_kind)
			BRK_ID1: begin
				b = 8'($urandom_range(0, 255));
				if (b == ghp_pkg::MAGIC_ID1)
					b = 8'h00;
				send_byte(b);
				send_byte(ghp_pkg::MAGIC_ID2);
			end
			BRK_ID2: begin
				b = 8'($urandom_range(0, 255));
				if (b == ghp_pkg::MAGIC_ID2 || b == ghp_pkg::MAGIC_ID2_OLD)
					b = 8'hFF;
				send_byte(ghp_pkg::MAGIC_ID1);
				send_byte(b);
			end
			default: begin
				if (closing_kind == BRK_CRYPT)
					flags = flags | ghp_pkg::FL_CRYPT;
				else if (closing_kind == BRK_MULTI)
					flags = (flags & ~ghp_pkg::FL_CRYPT) | ghp_pkg::FL_MULTI;
				else
					flags = (flags & ~(ghp_pkg::FL_CRYPT | ghp_pkg::FL_MULTI)) |
						(8'($urandom_range(1, 3)) << 6);
				send_byte(ghp_pkg::MAGIC_ID1);
				send_byte(ghp_pkg::MAGIC_ID2);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(flags);
			end
		endcase
		repeat (20) send_byte(8'($urandom_range(0, 255)));
	endtask

	// stimulus
	initial begin : stimulus
		int hdr_count;
		hdr_count = 0;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// old magic with a bare header, then every optional field present but empty
		send_header(ghp_pkg::MAGIC_ID2_OLD, 8'h00, 8'h00, 16'h0000, 0, 0);
		send_header(ghp_pkg::MAGIC_ID2, 8'hFF,
			ghp_pkg::FL_EXTRA | ghp_pkg::FL_NAME | ghp_pkg::FL_COMMENT | 8'h01,
			16'h0000, 0, 0);
		wait_results_drained();

		// back-to-back bytes against a long result hold-off
		hold_request = 1'b1;
		sender_burst = 1'b1;
		repeat (3) send_random_header();
		sender_burst = 1'b0;

		// random headers with a full drain now and then
		while (bytes_sent < TARGET_BYTES) begin
			send_random_header();
			hdr_count++;
			if (hdr_count % 40 == 0)
				wait_results_drained();
		end

		// the parser only leaves the stopped state through reset, so one error closes the run
		send_broken_header();
		byte_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("run covered %0d header bytes and %0d complete headers, closing on %s",
			bytes_sent, sb.headers_done, closing_kind.name());
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
rtl/ghp_pkg.sv
rtl/ghp_if.sv
rtl/gzip_header_parser_top.sv
rtl/ghp_checker.sv
tb/sv/tb_top.sv
